>>> rtl/pso_pkg.sv
// ----------------------------------------------------------------------------
// pso_pkg
// Shared types, constants and helper functions of the swarm update engine.
// ----------------------------------------------------------------------------
package pso_pkg;

  localparam int PARTICLES      = 64;
  localparam int DIMS           = 16;
  localparam int PRT_W          = $clog2(PARTICLES);
  localparam int DIM_W          = $clog2(DIMS);
  localparam int ADDR_W         = PRT_W + DIM_W;
  localparam int STORE_DEPTH    = PARTICLES * DIMS;
  localparam int N_W            = $clog2(DIMS + 1);
  localparam int COS_TABLE_BITS = 10;
  localparam int COS_FULL       = 1 << COS_TABLE_BITS;
  localparam int COS_HALF       = COS_FULL >> 1;
  localparam int COS_QUARTER    = COS_FULL >> 2;
  localparam int KF_W           = COS_TABLE_BITS - 1;
  localparam int FIT_W          = 47;
  localparam int SCORE_W        = 48;
  localparam int CFG_W          = 17;
  localparam int CFG_IDX_W      = 2;

  localparam logic [SCORE_W-1:0] FIT_MAX    = {1'b0, {FIT_W{1'b1}}};
  localparam logic [SCORE_W-1:0] SCORE_ONES = {SCORE_W{1'b1}};
  localparam logic [63:0]        Q30_ONE    = 64'h0000_0000_4000_0000;
  localparam logic [63:0]        HALF_PI_Q30 = 64'd1686629713;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_EVAL   = 2'd1;
  localparam logic [1:0] OP_UPDATE = 2'd2;
  localparam logic [1:0] OP_COMMIT = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_ETA  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAU  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIMS = 2'd2;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [PRT_W-1:0]   particle;
    logic [DIM_W-1:0]   dim;
    logic signed [31:0] position;
    logic signed [31:0] velocity;
    logic [15:0]        alpha;
    logic [15:0]        beta;
  } cmd_t;

  typedef struct packed {
    logic [FIT_W-1:0] fitness;
    logic             improved;
    logic [FIT_W-1:0] best_fitness;
    logic [PRT_W-1:0] best_particle;
  } result_t;

  typedef struct packed {
    logic [16:0] eta;
    logic [16:0] tau;
    logic [15:0] alpha;
    logic [15:0] beta;
  } coef_t;

  typedef logic [16:0] cos_rom_t [0:COS_QUARTER];

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic cos_rom_t cos_build();
    cos_rom_t    rom;
    logic [63:0] t;
    logic [63:0] u;
    logic [63:0] h;
    logic [63:0] prod;
    logic [63:0] c;
    for (int k = 0; k <= COS_QUARTER; k++) begin
      t    = (64'(k) * HALF_PI_Q30) / COS_QUARTER;
      u    = (t * t) >> 30;
      h    = Q30_ONE - u / 90;
      h    = Q30_ONE - ((u * h) >> 30) / 56;
      h    = Q30_ONE - ((u * h) >> 30) / 30;
      h    = Q30_ONE - ((u * h) >> 30) / 12;
      prod = ((u * h) >> 30) / 2;
      c    = (prod >= Q30_ONE) ? 64'd0 : Q30_ONE - prod;
      rom[k] = 17'((c + 64'd8192) >> 14);
    end
    return rom;
  endfunction

endpackage

>>> rtl/pso_ram.sv
// ----------------------------------------------------------------------------
// pso_ram
// Simple dual-port synchronous RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module pso_ram #(
  parameter int W  = 32,
  parameter int D  = 1024,
  parameter int AW = $clog2(D)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [0:D-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/pso_update.sv
// ----------------------------------------------------------------------------
// pso_update
// Four-stage pipeline for the velocity and position update of one element.
// ----------------------------------------------------------------------------
module pso_update import pso_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_vld,
  input  logic [DIM_W-1:0]   in_idx,
  input  logic signed [31:0] x,
  input  logic signed [31:0] v,
  input  logic signed [31:0] p,
  input  logic signed [31:0] g,
  input  coef_t              coef,
  output logic               out_vld,
  output logic [DIM_W-1:0]   out_idx,
  output logic signed [31:0] x_new,
  output logic signed [31:0] v_new
);

  logic               vld_a, vld_b, vld_c;
  logic [DIM_W-1:0]   idx_a, idx_b, idx_c;
  logic signed [49:0] pe, pa, pb;
  logic signed [31:0] x_a, x_b, x_c;
  logic signed [31:0] v_b, v_c;
  logic signed [49:0] tv;
  logic signed [51:0] acc;
  logic signed [32:0] dpx, dgx;
  logic signed [35:0] acc_sh;
  logic signed [34:0] xsum;

  assign dpx    = 33'(p) - 33'(x);
  assign dgx    = 33'(g) - 33'(x);
  assign acc    = 52'(pe) + 52'(pa) + 52'(pb);
  assign acc_sh = 36'(acc >>> 16);
  assign xsum   = 35'(x_c) + 35'(tv >>> 16);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a   <= 1'b0;
      vld_b   <= 1'b0;
      vld_c   <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      vld_a   <= in_vld;
      vld_b   <= vld_a;
      vld_c   <= vld_b;
      out_vld <= vld_c;
    end
    pe      <= $signed({1'b0, coef.eta}) * v;
    pa      <= $signed({1'b0, coef.alpha}) * dpx;
    pb      <= $signed({1'b0, coef.beta}) * dgx;
    x_a     <= x;
    idx_a   <= in_idx;
    v_b     <= sat32(64'(acc_sh));
    x_b     <= x_a;
    idx_b   <= idx_a;
    tv      <= $signed({1'b0, coef.tau}) * v_b;
    v_c     <= v_b;
    x_c     <= x_b;
    idx_c   <= idx_b;
    x_new   <= sat32(64'(xsum));
    v_new   <= v_c;
    out_idx <= idx_c;
  end

endmodule

>>> rtl/pso_fitness.sv
// ----------------------------------------------------------------------------
// pso_fitness
// Pipelined Rastrigin term with table cosine and a saturating accumulator.
// ----------------------------------------------------------------------------
module pso_fitness import pso_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               clr,
  input  logic               in_vld,
  input  logic signed [31:0] x,
  output logic               acc_vld,
  output logic [SCORE_W-1:0] sum
);

  localparam cos_rom_t COS_ROM = cos_build();

  logic                      vld_1, vld_2, vld_3;
  logic [31:0]               mag;
  logic [KF_W-1:0]           kf;
  logic                      neg_1, neg_2;
  logic [63:0]               sq;
  logic [16:0]               cm;
  logic [SCORE_W-1:0]        term;
  logic [COS_TABLE_BITS-1:0] k_raw;
  logic [COS_TABLE_BITS:0]   k_a;
  logic [COS_TABLE_BITS:0]   k_b;
  logic                      neg_f;
  logic [17:0]               om;
  logic [SCORE_W:0]          sum_add;

  assign k_raw = x[15 -: COS_TABLE_BITS];

  always_comb begin
    k_a   = {1'b0, k_raw};
    if (k_a > (COS_TABLE_BITS+1)'(COS_HALF)) begin
      k_a = (COS_TABLE_BITS+1)'(COS_FULL) - k_a;
    end
    neg_f = 1'b0;
    k_b   = k_a;
    if (k_a > (COS_TABLE_BITS+1)'(COS_QUARTER)) begin
      neg_f = 1'b1;
      k_b   = (COS_TABLE_BITS+1)'(COS_HALF) - k_a;
    end
  end

  assign om      = neg_2 ? 18'd65536 + 18'(cm) : 18'd65536 - 18'(cm);
  assign sum_add = {1'b0, sum} + {1'b0, term};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_1   <= 1'b0;
      vld_2   <= 1'b0;
      vld_3   <= 1'b0;
      acc_vld <= 1'b0;
      sum     <= '0;
    end else begin
      vld_1   <= in_vld;
      vld_2   <= vld_1;
      vld_3   <= vld_2;
      acc_vld <= vld_3 && !clr;
      if (clr) begin
        sum <= '0;
      end else if (vld_3) begin
        sum <= (sum_add > {1'b0, FIT_MAX}) ? FIT_MAX : sum_add[SCORE_W-1:0];
      end
    end
    mag   <= x[31] ? 32'(-33'(x)) : 32'(x);
    kf    <= k_b[KF_W-1:0];
    neg_1 <= neg_f;
    sq    <= 64'(mag) * 64'(mag);
    cm    <= COS_ROM[kf];
    neg_2 <= neg_1;
    term  <= sq[63:16] + SCORE_W'(om) * SCORE_W'(10);
  end

endmodule

>>> rtl/particle_swarm_update_engine.sv
// ----------------------------------------------------------------------------
// particle_swarm_update_engine
// Swarm state in RAMs; streams one element per cycle through the update and
// fitness pipelines and tracks the lowest fitness seen.
//
//   channel  ports                        handshake
//   command  start, busy, cmd             taken when start && !busy
//   result   result_valid, result         one-cycle strobe, no stall
//   config   cfg_we, cfg_index, cfg_data  written when cfg_we is high
//
// A load leaves busy low; its item shows the next cycle.
// The other items stream the active dimensions: an evaluate reads and scores
// them; an update also rewrites them and, when the personal best is replaced,
// copies them into it; a commit with a pending copy writes the best particle's
// position into the global best, and one without goes straight to its result.
// Reset is synchronous; the stores need no clearing pass.
// ----------------------------------------------------------------------------
module particle_swarm_update_engine import pso_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  cmd_t                 cmd,
  output logic                 result_valid,
  output result_t              result,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RUN    = 3'd1;
  localparam logic [2:0] S_DRAIN  = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_COPY   = 3'd4;
  localparam logic [2:0] S_FLUSH  = 3'd5;
  localparam logic [2:0] S_FINISH = 3'd6;

  logic [2:0]         state;
  logic [16:0]        eta, tau;
  logic [4:0]         adims;
  logic [1:0]         op;
  logic [PRT_W-1:0]   prt;
  logic [N_W-1:0]     n;
  logic [N_W-1:0]     cnt;
  logic [DIM_W-1:0]   idx;
  logic [DIM_W-1:0]   rd_idx;
  logic               rd_vld, cp_vld;
  logic [15:0]        alpha, beta;
  logic               improved;
  logic [SCORE_W-1:0] lowest;
  logic [PRT_W-1:0]   lowest_prt;
  logic               pending;
  logic signed [31:0] gvec [0:DIMS-1];

  logic               accept;
  logic               is_last;
  logic [N_W-1:0]     n_cl;
  logic               load_acc;
  logic [ADDR_W-1:0]  raddr;
  logic [31:0]        pos_q, vel_q, pb_q;
  logic [SCORE_W-1:0] score_q;
  logic               upd_vld;
  logic [DIM_W-1:0]   upd_idx;
  logic signed [31:0] upd_x, upd_v;
  logic               fit_vld;
  logic signed [31:0] fit_x;
  logic               acc_vld;
  logic [SCORE_W-1:0] sum;
  logic               pos_we;
  logic [ADDR_W-1:0]  pos_waddr;
  logic [31:0]        pos_wdata, vel_wdata;
  logic               pb_we;
  logic [ADDR_W-1:0]  pb_waddr;
  logic [31:0]        pb_wdata;
  logic               score_we;
  logic               scoring;
  logic               best_upd;
  coef_t              coef;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign load_acc = accept && (cmd.opcode == OP_LOAD);
  assign is_last  = ({1'b0, idx} == n - N_W'(1));
  assign raddr    = {prt, idx};
  assign coef     = '{eta: eta, tau: tau, alpha: alpha, beta: beta};
  assign scoring  = (op == OP_EVAL) || (op == OP_UPDATE);
  assign best_upd = scoring && (sum < lowest);

  always_comb begin
    n_cl = N_W'(adims);
    if (adims == 5'd0) begin
      n_cl = N_W'(1);
    end else if (N_W'(adims) > N_W'(DIMS)) begin
      n_cl = N_W'(DIMS);
    end
  end

  assign pos_we    = load_acc || upd_vld;
  assign pos_waddr = load_acc ? {cmd.particle, cmd.dim} : {prt, upd_idx};
  assign pos_wdata = load_acc ? cmd.position : upd_x;
  assign vel_wdata = load_acc ? cmd.velocity : upd_v;
  assign pb_we     = load_acc || (cp_vld && (op == OP_UPDATE));
  assign pb_waddr  = load_acc ? {cmd.particle, cmd.dim} : {prt, rd_idx};
  assign pb_wdata  = load_acc ? cmd.position : pos_q;
  assign score_we  = (state == S_FINISH) && ((op == OP_EVAL) || improved);
  assign fit_vld   = (rd_vld && (op == OP_EVAL)) || upd_vld;
  assign fit_x     = (op == OP_EVAL) ? pos_q : upd_x;

  pso_ram #(.W(32), .D(STORE_DEPTH)) u_pos (
    .clk(clk), .we(pos_we), .waddr(pos_waddr), .wdata(pos_wdata),
    .raddr(raddr), .rdata(pos_q)
  );

  pso_ram #(.W(32), .D(STORE_DEPTH)) u_vel (
    .clk(clk), .we(pos_we), .waddr(pos_waddr), .wdata(vel_wdata),
    .raddr(raddr), .rdata(vel_q)
  );

  pso_ram #(.W(32), .D(STORE_DEPTH)) u_pbest (
    .clk(clk), .we(pb_we), .waddr(pb_waddr), .wdata(pb_wdata),
    .raddr(raddr), .rdata(pb_q)
  );

  pso_ram #(.W(SCORE_W), .D(PARTICLES)) u_score (
    .clk(clk), .we(score_we), .waddr(prt), .wdata(sum),
    .raddr(prt), .rdata(score_q)
  );

  pso_update u_update (
    .clk(clk), .rst(rst),
    .in_vld(rd_vld && (op == OP_UPDATE)), .in_idx(rd_idx),
    .x(pos_q), .v(vel_q), .p(pb_q), .g(gvec[rd_idx]), .coef(coef),
    .out_vld(upd_vld), .out_idx(upd_idx), .x_new(upd_x), .v_new(upd_v)
  );

  pso_fitness u_fitness (
    .clk(clk), .rst(rst), .clr(accept), .in_vld(fit_vld), .x(fit_x),
    .acc_vld(acc_vld), .sum(sum)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      eta   <= 17'd6554;
      tau   <= 17'd65536;
      adims <= 5'd16;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ETA:  eta   <= cfg_data;
        CFG_TAU:  tau   <= cfg_data;
        CFG_DIMS: adims <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIMS; i++) begin
        gvec[i] <= '0;
      end
    end else if (cp_vld && (op == OP_COMMIT)) begin
      gvec[rd_idx] <= pos_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      rd_vld       <= 1'b0;
      cp_vld       <= 1'b0;
      result_valid <= 1'b0;
      lowest       <= SCORE_ONES;
      lowest_prt   <= '0;
      pending      <= 1'b0;
      cnt          <= '0;
      improved     <= 1'b0;
      op           <= OP_LOAD;
    end else begin
      rd_vld       <= (state == S_RUN);
      cp_vld       <= (state == S_COPY);
      rd_idx       <= idx;
      result_valid <= 1'b0;
      if (acc_vld) begin
        cnt <= cnt + N_W'(1);
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            op       <= cmd.opcode;
            prt      <= (cmd.opcode == OP_COMMIT) ? lowest_prt : cmd.particle;
            n        <= n_cl;
            alpha    <= cmd.alpha;
            beta     <= cmd.beta;
            idx      <= '0;
            cnt      <= '0;
            improved <= 1'b0;
            case (cmd.opcode)
              OP_LOAD: begin
                result_valid <= 1'b1;
                result       <= '{fitness: '0, improved: 1'b0,
                                  best_fitness: lowest[FIT_W-1:0],
                                  best_particle: lowest_prt};
              end
              OP_EVAL, OP_UPDATE: state <= S_RUN;
              OP_COMMIT: state <= pending ? S_COPY : S_FINISH;
              default: ;
            endcase
          end
        end
        S_RUN: begin
          if (is_last) begin
            state <= S_DRAIN;
          end else begin
            idx <= idx + DIM_W'(1);
          end
        end
        S_DRAIN: begin
          if (cnt == n) begin
            state <= (op == OP_UPDATE) ? S_DECIDE : S_FINISH;
          end
        end
        S_DECIDE: begin
          idx <= '0;
          if (sum < score_q) begin
            improved <= 1'b1;
            state    <= S_COPY;
          end else begin
            state <= S_FINISH;
          end
        end
        S_COPY: begin
          if (is_last) begin
            state <= S_FLUSH;
          end else begin
            idx <= idx + DIM_W'(1);
          end
        end
        S_FLUSH: state <= S_FINISH;
        S_FINISH: begin
          state        <= S_IDLE;
          result_valid <= 1'b1;
          result.fitness  <= scoring ? sum[FIT_W-1:0] : '0;
          result.improved <= improved;
          if (best_upd) begin
            lowest     <= sum;
            lowest_prt <= prt;
            pending    <= 1'b1;
            result.best_fitness  <= sum[FIT_W-1:0];
            result.best_particle <= prt;
          end else begin
            result.best_fitness  <= lowest[FIT_W-1:0];
            result.best_particle <= lowest_prt;
          end
          if (op == OP_COMMIT) begin
            pending <= 1'b0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_lowest_mono: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> lowest <= $past(lowest))
    else $error("Lowest fitness rose.");

  a_improved_op: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.improved |-> op == OP_UPDATE)
    else $error("Improved flag set outside an update.");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    accept && cmd.opcode != OP_LOAD |=> busy)
    else $error("Block did not go busy after taking a multi-cycle item.");

  a_no_result_running: assert property (@(posedge clk) disable iff (rst)
    state == S_RUN || state == S_COPY |-> !result_valid)
    else $error("Result item shown while elements are still streaming.");
`endif

endmodule

>>> verif/particle_swarm_update_engine_tb.sv
// ----------------------------------------------------------------------------
// Swarm update engine testbench
// Drives load, evaluate, update and commit items through the command port in
// random bursts, predicts every result with a fixed-point swarm predictor
// held in a small scoreboard, and compares each result strobe field by field.
// Configuration is changed between phases, with the block idle.
// ----------------------------------------------------------------------------
module particle_swarm_update_engine_tb;
  import pso_pkg::*;

  localparam int IDLE_LIMIT   = 4000;

  class swarm_scoreboard;
    int               pos_mem [STORE_DEPTH];
    int               vel_mem [STORE_DEPTH];
    int               pbest_mem [STORE_DEPTH];
    longint unsigned  pbest_score [PARTICLES];
    int               gbest_vec [DIMS];
    longint unsigned  low_score;
    bit [PRT_W-1:0]   low_particle;
    bit               commit_due;
    bit [16:0]        eta;
    bit [16:0]        tau;
    bit [4:0]         dims_reg;
    result_t          pending_q [$];
    int               errors;

    function new();
      foreach (gbest_vec[i]) gbest_vec[i] = 0;
      foreach (pbest_score[i]) pbest_score[i] = 0;
      low_score    = 48'hFFFF_FFFF_FFFF;
      low_particle = '0;
      commit_due   = 1'b0;
      eta          = 17'd6554;
      tau          = 17'd65536;
      dims_reg     = 5'd16;
      errors       = 0;
    endfunction

    function void write_reg(bit [CFG_IDX_W-1:0] idx, bit [CFG_W-1:0] val);
      if (idx == CFG_ETA) eta = val;
      else if (idx == CFG_TAU) tau = val;
      else if (idx == CFG_DIMS) dims_reg = val[4:0];
    endfunction

    function int dims_used();
      if (dims_reg < 1) return 1;
      if (dims_reg > DIMS) return DIMS;
      return dims_reg;
    endfunction

    function int clip32(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return int'(v);
    endfunction

    function longint unsigned cos_mag(int k, output bit neg);
      longint unsigned t, u, h, prod, c;
      neg = 1'b0;
      k = k & (COS_FULL - 1);
      if (k > COS_HALF) k = COS_FULL - k;
      if (k > COS_QUARTER) begin
        neg = 1'b1;
        k = COS_HALF - k;
      end
      t    = (longint'(k) * 64'd1686629713) / COS_QUARTER;
      u    = (t * t) >> 30;
      h    = 64'h4000_0000 - u / 90;
      h    = 64'h4000_0000 - ((u * h) >> 30) / 56;
      h    = 64'h4000_0000 - ((u * h) >> 30) / 30;
      h    = 64'h4000_0000 - ((u * h) >> 30) / 12;
      prod = ((u * h) >> 30) / 2;
      c    = (prod >= 64'h4000_0000) ? 64'd0 : 64'h4000_0000 - prod;
      return (c + 64'd8192) >> 14;
    endfunction

    function longint unsigned rastrigin_fit(int base, int n);
      longint unsigned sum, mag, cm, one_minus;
      longint          x;
      bit              neg;
      bit [31:0]       raw;
      sum = 0;
      for (int i = 0; i < n; i++) begin
        x   = pos_mem[base + i];
        raw = pos_mem[base + i];
        mag = (x < 0) ? -x : x;
        cm  = cos_mag(int'(raw[15:16-COS_TABLE_BITS]), neg);
        one_minus = neg ? 65536 + cm : 65536 - cm;
        sum += ((mag * mag) >> 16) + 10 * one_minus;
        if (sum > 64'h7FFF_FFFF_FFFF) sum = 64'h7FFF_FFFF_FFFF;
      end
      return sum;
    endfunction

    function void track_low(longint unsigned fit, bit [PRT_W-1:0] p);
      if (fit < low_score) begin
        low_score    = fit;
        low_particle = p;
        commit_due   = 1'b1;
      end
    endfunction

    function void note(cmd_t c);
      result_t         e;
      int              base, n, v;
      longint          x, acc;
      longint unsigned fit;
      bit              better;
      base   = int'(c.particle) * DIMS;
      n      = dims_used();
      fit    = 0;
      better = 1'b0;
      case (c.opcode)
        OP_LOAD: begin
          pos_mem[base + c.dim]   = c.position;
          vel_mem[base + c.dim]   = c.velocity;
          pbest_mem[base + c.dim] = c.position;
        end
        OP_EVAL: begin
          fit = rastrigin_fit(base, n);
          pbest_score[c.particle] = fit;
          track_low(fit, c.particle);
        end
        OP_UPDATE: begin
          for (int i = 0; i < n; i++) begin
            x   = pos_mem[base + i];
            acc = longint'(eta) * vel_mem[base + i]
                + longint'(c.alpha) * (longint'(pbest_mem[base + i]) - x)
                + longint'(c.beta) * (longint'(gbest_vec[i]) - x);
            v = clip32(acc >>> 16);
            vel_mem[base + i] = v;
            pos_mem[base + i] = clip32(x + ((longint'(tau) * v) >>> 16));
          end
          fit = rastrigin_fit(base, n);
          if (fit < pbest_score[c.particle]) begin
            for (int i = 0; i < n; i++) pbest_mem[base + i] = pos_mem[base + i];
            pbest_score[c.particle] = fit;
            better = 1'b1;
          end
          track_low(fit, c.particle);
        end
        default: begin
          if (commit_due)
            for (int i = 0; i < n; i++) gbest_vec[i] = pos_mem[int'(low_particle) * DIMS + i];
          commit_due = 1'b0;
        end
      endcase
      e.fitness       = fit[FIT_W-1:0];
      e.improved      = better;
      e.best_fitness  = low_score[FIT_W-1:0];
      e.best_particle = low_particle;
      pending_q.push_back(e);
    endfunction

    function void check(result_t r);
      result_t e;
      if (pending_q.size() == 0) begin
        $error("unexpected result item: fitness %0d", r.fitness);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (r.fitness !== e.fitness) begin
        $error("fitness: expected %0d, got %0d", e.fitness, r.fitness);
        errors++;
      end
      if (r.improved !== e.improved) begin
        $error("improved: expected %0d, got %0d", e.improved, r.improved);
        errors++;
      end
      if (r.best_fitness !== e.best_fitness) begin
        $error("best_fitness: expected %0d, got %0d", e.best_fitness, r.best_fitness);
        errors++;
      end
      if (r.best_particle !== e.best_particle) begin
        $error("best_particle: expected %0d, got %0d", e.best_particle, r.best_particle);
        errors++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  cmd_t                 cmd = '0;
  logic                 result_valid;
  result_t              result;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  swarm_scoreboard sb = new();
  bit              loaded [PARTICLES][DIMS];
  bit              scored [PARTICLES];
  int              burst_left;
  int              idle_cycles;
  int              sent;

  particle_swarm_update_engine dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .result_valid(result_valid), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && result_valid) sb.check(result);
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_item(cmd_t c);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 60 : 4)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 6);
    end
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy);
    sb.note(c);
    if (c.opcode == OP_LOAD) loaded[c.particle][c.dim] = 1'b1;
    if (c.opcode == OP_EVAL) scored[c.particle] = 1'b1;
    burst_left--;
    sent++;
  endtask

  task automatic settle();
    start <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(bit [CFG_IDX_W-1:0] idx, bit [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(bit [CFG_W-1:0] e, bit [CFG_W-1:0] t, bit [CFG_W-1:0] d);
    settle();
    write_reg(CFG_ETA, e);
    write_reg(CFG_TAU, t);
    write_reg(CFG_DIMS, d);
  endtask

  function automatic cmd_t make_cmd(bit [1:0] op, int p, int d, int x, int v,
                                    int a, int b);
    cmd_t c;
    c.opcode   = op;
    c.particle = PRT_W'(p);
    c.dim      = DIM_W'(d);
    c.position = x;
    c.velocity = v;
    c.alpha    = 16'(a);
    c.beta     = 16'(b);
    return c;
  endfunction

  function automatic cmd_t noise(bit [1:0] op, int p);
    return make_cmd(op, p, $urandom, $urandom, $urandom, $urandom, $urandom);
  endfunction

  function automatic int rand_coord();
    if ($urandom_range(0, 7) == 0) return $urandom;
    return int'($urandom_range(0, 786432)) - 393216;
  endfunction

  function automatic bit ready(int p);
    for (int d = 0; d < DIMS; d++) if (!loaded[p][d]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic int pick_ready(bit need_score);
    int p;
    for (int tries = 0; tries < 40; tries++) begin
      p = $urandom_range(0, 11);
      if ($urandom_range(0, 5) == 0) p = $urandom_range(0, PARTICLES - 1);
      if (ready(p) && (!need_score || scored[p])) return p;
    end
    return -1;
  endfunction

  task automatic init_particle(int p);
    for (int d = 0; d < DIMS; d++)
      send_item(make_cmd(OP_LOAD, p, d, rand_coord(), rand_coord(), $urandom, $urandom));
    send_item(noise(OP_EVAL, p));
  endtask

  task automatic random_phase(int count);
    int stop, p, sel;
    stop = sent + count;
    while (sent < stop) begin
      sel = $urandom_range(0, 9);
      p = pick_ready(sel < 7);
      if (sel < 2 || p < 0) begin
        init_particle($urandom_range(0, ($urandom_range(0, 4) == 0) ? PARTICLES - 1 : 11));
      end else if (sel < 7) begin
        repeat ($urandom_range(1, 4)) send_item(noise(OP_UPDATE, p));
        if ($urandom_range(0, 1) == 0) send_item(noise(OP_COMMIT, $urandom));
      end else if (sel == 7) begin
        if (!sb.commit_due || ready(sb.low_particle)) send_item(noise(OP_COMMIT, $urandom));
      end else if (sel == 8) begin
        send_item(make_cmd(OP_LOAD, $urandom, $urandom, rand_coord(), rand_coord(),
                           $urandom, $urandom));
      end else begin
        send_item(noise(OP_EVAL, p));
      end
    end
  endtask

  initial begin
    burst_left  = 0;
    idle_cycles = 0;
    sent        = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Two dimensions in use; particle 0 holds the extreme coordinates.
    write_reg(CFG_DIMS, 17'd2);
    send_item(make_cmd(OP_COMMIT, 5, 0, 0, 0, 0, 0));
    send_item(make_cmd(OP_LOAD, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0));
    send_item(make_cmd(OP_LOAD, 0, 1, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0));
    send_item(make_cmd(OP_LOAD, 63, 15, 32'hFFFF_FFFF, 32'h0000_0000, 16'hFFFF, 16'hFFFF));
    send_item(make_cmd(OP_EVAL, 0, 0, 0, 0, 0, 0));
    send_item(make_cmd(OP_COMMIT, 0, 0, 0, 0, 0, 0));
    send_item(make_cmd(OP_COMMIT, 0, 0, 0, 0, 0, 0));
    send_item(make_cmd(OP_UPDATE, 0, 0, 0, 0, 16'hFFFF, 16'hFFFF));
    send_item(make_cmd(OP_UPDATE, 0, 0, 0, 0, 0, 0));
    send_item(make_cmd(OP_LOAD, 0, 0, 32'h0001_8000, 32'h0000_4000, 0, 0));
    send_item(make_cmd(OP_LOAD, 0, 1, 32'hFFFF_C000, 32'hFFFF_0000, 0, 0));
    send_item(make_cmd(OP_UPDATE, 0, 0, 0, 0, 16'h8000, 16'h0001));
    send_item(make_cmd(OP_EVAL, 0, 0, 0, 0, 0, 0));
    send_item(make_cmd(OP_COMMIT, 0, 0, 0, 0, 0, 0));
    configure(17'd0, 17'd0, 17'd0);
    send_item(make_cmd(OP_UPDATE, 0, 0, 0, 0, 16'h1234, 16'hFEDC));
    send_item(make_cmd(OP_EVAL, 0, 0, 0, 0, 0, 0));
    send_item(make_cmd(OP_COMMIT, 0, 0, 0, 0, 0, 0));

    configure(17'd6554, 17'd65536, 17'd16);
    random_phase(300);
    configure(17'd65536, 17'd65536, 17'd16);
    random_phase(200);
    configure(17'h1FFFF, 17'h1FFFF, 17'h1F);
    random_phase(200);
    configure(17'd0, 17'd0, 17'd1);
    random_phase(150);
    configure(CFG_W'($urandom_range(0, 65536)), CFG_W'($urandom_range(0, 65536)),
              CFG_W'($urandom_range(1, 16)));
    random_phase(200);
    configure(17'd32768, 17'd16384, 17'd5);
    random_phase(200);

    start <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

>>> files.f
rtl/pso_pkg.sv
rtl/pso_ram.sv
rtl/pso_update.sv
rtl/pso_fitness.sv
rtl/particle_swarm_update_engine.sv
verif/particle_swarm_update_engine_tb.sv
